// ===== design/pbx_pkg.sv =====
// Package for the protobuf length-delimited field extractor.
// Shared types, parse phase and outcome codes, and the per-item result struct.
// No dependencies.
package pbx_pkg;

    localparam int unsigned LEN_BITS_DEF = 32;
    localparam int unsigned FIELD_W      = 29;
    localparam int unsigned TLEN_W       = 32;
    localparam int unsigned ACC_W        = 64;
    localparam int unsigned CNT_W        = 4;
    localparam logic [FIELD_W-1:0] TARGET_RESET = FIELD_W'(6);

    // wire types and varint limits
    localparam logic [2:0]       WT_VARINT   = 3'd0;
    localparam logic [2:0]       WT_LEN      = 3'd2;
    localparam logic [CNT_W-1:0] VARINT_LAST = CNT_W'(9);

    typedef enum logic [2:0] {
        PH_TAG,
        PH_SKIPVAR,
        PH_SKIPLEN,
        PH_SKIPBYTES,
        PH_TOKLEN,
        PH_EMIT,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        OUT_NOTFOUND  = 2'd0,
        OUT_FOUND     = 2'd1,
        OUT_MALFORMED = 2'd2
    } t_outcome;

    typedef struct packed {
        logic [7:0]        token_byte;
        logic              token_byte_valid;
        logic              finished;
        t_outcome          outcome;
        logic [TLEN_W-1:0] token_length;
    } t_result;

endpackage

// ===== design/pbx_core.sv =====
// Parse core of the field extractor: state registers and one-byte state update.
// Result for the presented byte is combinational; depends on pbx_pkg.
module pbx_core import pbx_pkg::*; #(
    parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    input  logic [FIELD_W-1:0] i_target,
    output t_result            o_res
);

    localparam logic [ACC_W-1:0] LenMask = {ACC_W{1'b1}} >> (ACC_W - LEN_BITS);
    localparam logic [LEN_BITS-1:0] LenOne = LEN_BITS'(1);

    t_phase              r_phase,   n_phase;
    logic [ACC_W-1:0]    r_acc,     n_acc;
    logic [CNT_W-1:0]    r_cnt,     n_cnt;
    logic [LEN_BITS-1:0] r_rem,     n_rem;
    logic [LEN_BITS-1:0] r_matched, n_matched;
    t_outcome            r_latched, n_latched;

    logic [CNT_W-1:0] cnt;
    logic [5:0]       shamt;
    logic [ACC_W-1:0] acc;
    logic [LEN_BITS-1:0] rem_dec;
    logic             len_over;
    logic             fnum_hit;
    logic [ACC_W-1:0] matched_ext;

    assign cnt      = (r_cnt > VARINT_LAST) ? VARINT_LAST : r_cnt;
    assign shamt    = 6'({2'b00, cnt} * 6'd7);
    assign acc      = r_acc | ({{(ACC_W-7){1'b0}}, i_byte[6:0]} << shamt);
    assign rem_dec  = r_rem - LenOne;
    assign len_over = |(acc & ~LenMask);
    assign fnum_hit = (acc[ACC_W-1:FIELD_W+3] == '0) && (acc[FIELD_W+2:3] == i_target);

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_matched = r_matched;
        n_latched = r_latched;
        unique case (r_phase)
            PH_TAG, PH_SKIPVAR, PH_SKIPLEN, PH_TOKLEN: begin
                if (i_byte[7]) begin
                    if (cnt >= VARINT_LAST) begin
                        n_phase   = PH_DONE;
                        n_latched = OUT_MALFORMED;
                        n_acc     = '0;
                        n_cnt     = '0;
                    end else begin
                        n_acc = acc;
                        n_cnt = cnt + CNT_W'(1);
                    end
                end else begin
                    n_acc = '0;
                    n_cnt = '0;
                    unique case (r_phase)
                        PH_TAG: begin
                            if (fnum_hit && acc[2:0] == WT_LEN) begin
                                n_phase = PH_TOKLEN;
                            end else if (acc[2:0] == WT_VARINT) begin
                                n_phase = PH_SKIPVAR;
                            end else if (acc[2:0] == WT_LEN) begin
                                n_phase = PH_SKIPLEN;
                            end else begin
                                n_phase   = PH_DONE;
                                n_latched = OUT_MALFORMED;
                            end
                        end
                        PH_SKIPVAR: begin
                            n_phase = PH_TAG;
                        end
                        PH_SKIPLEN: begin
                            if (len_over) begin
                                n_phase   = PH_DONE;
                                n_latched = OUT_MALFORMED;
                            end else if (acc == '0) begin
                                n_phase = PH_TAG;
                            end else begin
                                n_rem   = acc[LEN_BITS-1:0];
                                n_phase = PH_SKIPBYTES;
                            end
                        end
                        default: begin
                            if (len_over) begin
                                n_phase   = PH_DONE;
                                n_latched = OUT_MALFORMED;
                            end else begin
                                n_matched = acc[LEN_BITS-1:0];
                                if (acc == '0) begin
                                    n_phase   = PH_DONE;
                                    n_latched = OUT_FOUND;
                                end else begin
                                    n_rem   = acc[LEN_BITS-1:0];
                                    n_phase = PH_EMIT;
                                end
                            end
                        end
                    endcase
                end
            end
            PH_SKIPBYTES: begin
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    n_phase = PH_TAG;
                end
            end
            PH_EMIT: begin
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    n_phase   = PH_DONE;
                    n_latched = OUT_FOUND;
                    n_acc     = '0;
                    n_cnt     = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign matched_ext = ACC_W'(n_matched);

    // result for this byte
    always_comb begin
        o_res                  = '0;
        o_res.finished         = i_last;
        o_res.token_byte_valid = (r_phase == PH_EMIT);
        o_res.token_byte       = (r_phase == PH_EMIT) ? i_byte : 8'h00;
        if (i_last) begin
            if (n_phase == PH_DONE) begin
                o_res.outcome = n_latched;
            end else if (n_phase == PH_TAG && n_cnt == '0) begin
                o_res.outcome = OUT_NOTFOUND;
            end else begin
                o_res.outcome = OUT_MALFORMED;
            end
            if (o_res.outcome == OUT_FOUND) begin
                o_res.token_length = matched_ext[TLEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TAG;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_rem     <= '0;
            r_matched <= '0;
            r_latched <= OUT_NOTFOUND;
        end else if (i_en) begin
            if (i_last) begin
                r_phase   <= PH_TAG;
                r_acc     <= '0;
                r_cnt     <= '0;
                r_rem     <= '0;
                r_matched <= '0;
                r_latched <= OUT_NOTFOUND;
            end else begin
                r_phase   <= n_phase;
                r_acc     <= n_acc;
                r_cnt     <= n_cnt;
                r_rem     <= n_rem;
                r_matched <= n_matched;
                r_latched <= n_latched;
            end
        end
    end

endmodule

// ===== design/protobuf_length_field_extractor_top.sv =====
// Every payload byte yields one result transfer in the cycle after it is taken, and a
// new byte can be taken every cycle while the output is not stalled: the next parse state
// is combinational and one output register holds the result. The input stalls only while
// that register is full and the output side is not ready. The result of the byte
// marked tlast carries the outcome and, when found, the declared length.
// Top level of the protobuf length-delimited field extractor; uses pbx_pkg, pbx_core.
module protobuf_length_field_extractor_top import pbx_pkg::*; #(
    parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [FIELD_W-1:0] i_cfg_wdata,      // target_field
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,   // [7:0] data_byte
    input  logic               i_s_axis_tlast,   // last
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [39:0]        o_m_axis_tdata,   // [7:0] token_byte, [39:8] token_length
    output logic               o_m_axis_tlast,   // finished
    output logic [2:0]         o_m_axis_tuser    // [0] token_byte_valid, [2:1] outcome
);

    logic [FIELD_W-1:0] r_target;
    logic               r_valid;
    t_result            r_res;
    t_result            res;
    logic               take;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign take            = i_s_axis_tvalid && o_s_axis_tready;

    pbx_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (take),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .i_target (r_target),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {r_res.token_length, r_res.token_byte};
    assign o_m_axis_tlast  = r_res.finished;
    assign o_m_axis_tuser  = {r_res.outcome, r_res.token_byte_valid};

endmodule

// ===== design/pbx_checker.sv =====
// Port-level checks for the field extractor top, attached by bind.
// Depends on pbx_pkg and protobuf_length_field_extractor_top.
module pbx_checker import pbx_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic [2:0]  o_m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    a_outcome_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tuser[2:1] == OUT_NOTFOUND)
        else $error("outcome on non-final transfer");

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser[2:1] != 2'd3)
        else $error("bad outcome code");

    a_len_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[39:8] != '0 |->
            o_m_axis_tlast && o_m_axis_tuser[2:1] == OUT_FOUND)
        else $error("length without found outcome");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[7:0] == 8'h00)
        else $error("token byte set while not valid");

endmodule

bind protobuf_length_field_extractor_top pbx_checker u_pbx_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== dv/protobuf_length_field_extractor_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for protobuf_length_field_extractor_top: protobuf payloads in,
// one result transfer per byte out, each checked against an in-bench field parser.
// Depends on pbx_pkg and the extractor RTL only.
module protobuf_length_field_extractor_top_test;
    import pbx_pkg::*;

    localparam int unsigned LEN_W      = LEN_BITS_DEF;
    localparam int unsigned WDOG_LIMIT = 2000;
    localparam int unsigned PHASE_BYTES = 48;

    class field_token_scoreboard;
        logic [FIELD_W-1:0] target;
        t_phase             phase;
        logic [ACC_W-1:0]   acc;
        logic [CNT_W-1:0]   vcount;
        logic [LEN_W-1:0]   remaining;
        logic [LEN_W-1:0]   matched_len;
        t_outcome           latched;
        t_result            expected_results[$];
        int                 mismatches;
        int                 results_seen;
        int                 outcome_count[3];

        function new();
            target       = TARGET_RESET;
            mismatches   = 0;
            results_seen = 0;
            foreach (outcome_count[k]) outcome_count[k] = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase       = PH_TAG;
            acc         = '0;
            vcount      = '0;
            remaining   = '0;
            matched_len = '0;
            latched     = OUT_NOTFOUND;
        endfunction

        function void close_payload(t_outcome o);
            phase   = PH_DONE;
            latched = o;
            acc     = '0;
            vcount  = '0;
        endfunction

        function void finish_varint(logic [ACC_W-1:0] v);
            logic [2:0]        wt;
            logic [ACC_W-4:0]  fnum;
            case (phase)
                PH_TAG: begin
                    wt   = v[2:0];
                    fnum = v[ACC_W-1:3];
                    if (fnum == (ACC_W-3)'(target) && wt == WT_LEN) phase = PH_TOKLEN;
                    else if (wt == WT_VARINT) phase = PH_SKIPVAR;
                    else if (wt == WT_LEN) phase = PH_SKIPLEN;
                    else close_payload(OUT_MALFORMED);
                end
                PH_SKIPVAR: phase = PH_TAG;
                PH_SKIPLEN: begin
                    if ((v >> LEN_W) != 0) begin
                        close_payload(OUT_MALFORMED);
                    end else if (v == 0) begin
                        phase = PH_TAG;
                    end else begin
                        remaining = v[LEN_W-1:0];
                        phase     = PH_SKIPBYTES;
                    end
                end
                default: begin
                    if ((v >> LEN_W) != 0) begin
                        close_payload(OUT_MALFORMED);
                    end else begin
                        matched_len = v[LEN_W-1:0];
                        if (v == 0) begin
                            close_payload(OUT_FOUND);
                        end else begin
                            remaining = v[LEN_W-1:0];
                            phase     = PH_EMIT;
                        end
                    end
                end
            endcase
        endfunction

        function void note_payload_byte(logic [7:0] b, logic last);
            t_result          r;
            logic [CNT_W-1:0] cnt;
            logic [ACC_W-1:0] v;
            int unsigned      sh;
            r = '0;
            case (phase)
                PH_TAG, PH_SKIPVAR, PH_SKIPLEN, PH_TOKLEN: begin
                    cnt = (vcount > VARINT_LAST) ? VARINT_LAST : vcount;
                    sh  = 7 * int'(cnt);
                    acc = acc | (ACC_W'(b[6:0]) << sh);
                    if (b[7]) begin
                        if (cnt >= VARINT_LAST) close_payload(OUT_MALFORMED);
                        else vcount = cnt + 1'b1;
                    end else begin
                        v      = acc;
                        acc    = '0;
                        vcount = '0;
                        finish_varint(v);
                    end
                end
                PH_SKIPBYTES: begin
                    remaining = remaining - 1'b1;
                    if (remaining == 0) phase = PH_TAG;
                end
                PH_EMIT: begin
                    r.token_byte       = b;
                    r.token_byte_valid = 1'b1;
                    remaining = remaining - 1'b1;
                    if (remaining == 0) close_payload(OUT_FOUND);
                end
                default: ;
            endcase
            r.finished = last;
            if (last) begin
                if (phase == PH_DONE) r.outcome = latched;
                else if (phase == PH_TAG && vcount == 0) r.outcome = OUT_NOTFOUND;
                else r.outcome = OUT_MALFORMED;
                if (r.outcome == OUT_FOUND) r.token_length = TLEN_W'(matched_len);
                clear_parse();
            end
            expected_results.insert(expected_results.size(), r);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
                     $realtime, results_seen, what, got, want);
            mismatches++;
        endtask

        task check_result(logic [39:0] tdata, logic tlast, logic [2:0] tuser);
            t_result want;
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transfer", 64'(tdata), 64'd0);
                return;
            end
            want = expected_results.pop_front();
            if (tdata[7:0] !== want.token_byte)
                report_mismatch("token_byte", 64'(tdata[7:0]), 64'(want.token_byte));
            if (tuser[0] !== want.token_byte_valid)
                report_mismatch("token_byte_valid", 64'(tuser[0]), 64'(want.token_byte_valid));
            if (tlast !== want.finished)
                report_mismatch("finished", 64'(tlast), 64'(want.finished));
            if (tuser[2:1] !== want.outcome)
                report_mismatch("outcome", 64'(tuser[2:1]), 64'(want.outcome));
            if (tdata[39:8] !== want.token_length)
                report_mismatch("token_length", 64'(tdata[39:8]), 64'(want.token_length));
            if (want.finished) outcome_count[int'(want.outcome)]++;
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_we        = 1'b0;
    logic [FIELD_W-1:0] i_cfg_wdata     = '0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [7:0]         i_s_axis_tdata  = '0;
    logic               i_s_axis_tlast  = 1'b0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [39:0]        o_m_axis_tdata;
    logic               o_m_axis_tlast;
    logic [2:0]         o_m_axis_tuser;

    field_token_scoreboard sb;
    logic [7:0]  payload_bytes[$];
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned idle_cycles    = 0;
    int          bytes_sent     = 0;
    int          payloads_sent  = 0;
    int          targets_written = 0;

    protobuf_length_field_extractor_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // result side: check, random stall, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        if (i_rst_n && ((o_m_axis_tvalid && i_m_axis_tready) ||
                        (i_s_axis_tvalid && o_s_axis_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WDOG_LIMIT);
            $display("protobuf_length_field_extractor_top_test: done, errors");
            $finish;
        end
    end

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v >> $urandom_range(0, 63);
    endfunction

    function automatic int unsigned pad_count();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0;
    endfunction

    function automatic logic [ACC_W-4:0] pick_field_number(logic [FIELD_W-1:0] tgt);
        logic [ACC_W-4:0] f;
        case ($urandom_range(0, 6))
            0: f = (ACC_W-3)'(tgt);
            1: f = (ACC_W-3)'(tgt) + 1'b1;
            2: f = (ACC_W-3)'($urandom_range(1, 20));
            3: f = '0;
            4: f = (ACC_W-3)'({FIELD_W{1'b1}});
            5: f = (ACC_W-3)'(rand_value() >> 3);
            default: f = (ACC_W-3)'(tgt) | ((ACC_W-3)'(1) << (29 + $urandom_range(0, 31)));
        endcase
        return f;
    endfunction

    // padded encodings stop at ten bytes
    function automatic void push_varint(logic [63:0] value, int unsigned pad);
        int unsigned nbytes;
        logic [63:0] rest;
        nbytes = 1;
        rest   = value >> 7;
        while (rest != 0) begin
            nbytes++;
            rest = rest >> 7;
        end
        nbytes = (nbytes + pad > 10) ? 10 : nbytes + pad;
        for (int unsigned i = 0; i < nbytes; i++) begin
            payload_bytes.insert(payload_bytes.size(), {(i != nbytes - 1), value[6:0]});
            value = value >> 7;
        end
    endfunction

    function automatic void build_payload(logic [FIELD_W-1:0] tgt);
        int unsigned      kind;
        int unsigned      len;
        int unsigned      cut;
        logic [2:0]       wt;
        logic [ACC_W-4:0] fnum;
        logic [63:0]      val;
        payload_bytes.delete();
        repeat ($urandom_range(1, 4)) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                push_varint({pick_field_number(tgt), WT_VARINT}, pad_count());
                push_varint(rand_value(), pad_count());
            end else if (kind < 75) begin
                fnum = (kind < 50) ? (ACC_W-3)'(tgt) : pick_field_number(tgt);
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                   : $urandom_range(0, 6);
                push_varint({fnum, WT_LEN}, pad_count());
                push_varint(64'(len), pad_count());
                if ($urandom_range(0, 9) == 0) len = $urandom_range(0, len);
                repeat (len) payload_bytes.insert(payload_bytes.size(), 8'($urandom));
            end else if (kind < 82) begin
                wt = 3'($urandom_range(1, 7));
                if (wt == WT_LEN) wt = 3'd1;
                push_varint({pick_field_number(tgt), wt}, pad_count());
                repeat ($urandom_range(0, 3))
                    payload_bytes.insert(payload_bytes.size(), 8'($urandom));
            end else if (kind < 87) begin
                // varint running past ten bytes
                if ($urandom_range(0, 1) == 1)
                    push_varint({pick_field_number(tgt), WT_LEN}, 0);
                repeat ($urandom_range(10, 12))
                    payload_bytes.insert(payload_bytes.size(), 8'h80 | 8'($urandom));
                payload_bytes.insert(payload_bytes.size(), 8'h00);
            end else if (kind < 92) begin
                // length wider than the length counter
                fnum = ($urandom_range(0, 1) == 1) ? (ACC_W-3)'(tgt) : pick_field_number(tgt);
                push_varint({fnum, WT_LEN}, 0);
                val = rand_value();
                val[LEN_W + $urandom_range(0, 63 - LEN_W)] = 1'b1;
                push_varint(val, pad_count());
            end else begin
                repeat ($urandom_range(1, 5))
                    payload_bytes.insert(payload_bytes.size(), 8'($urandom));
            end
        end
        if ($urandom_range(0, 9) == 0 && payload_bytes.size() > 1) begin
            cut = $urandom_range(1, payload_bytes.size() - 1);
            repeat (cut) void'(payload_bytes.pop_back());
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_payload_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_payload();
        foreach (payload_bytes[k])
            send_byte(payload_bytes[k], k == payload_bytes.size() - 1);
        payloads_sent++;
    endtask

    task automatic write_target(input logic [FIELD_W-1:0] value);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.target = value;
        targets_written++;
    endtask

    initial begin
        logic [FIELD_W-1:0] tgt;
        int                 phase_bytes;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset target 6
        payload_bytes = '{8'h32, 8'h02, 8'h00, 8'hFF, 8'hAA};
        send_payload();
        payload_bytes = '{8'h32, 8'h00};
        send_payload();
        payload_bytes = '{8'h08, 8'h96, 8'h01, 8'h12, 8'h01, 8'h7F};
        send_payload();
        payload_bytes = '{8'h0D, 8'h55};
        send_payload();
        payload_bytes.delete();
        repeat (10) payload_bytes.insert(payload_bytes.size(), 8'hFF);
        send_payload();
        i_s_axis_tvalid <= 1'b0;

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 68; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 68; end
                default: begin src_idle_pct = 19; sink_stall_pct = 19; end
            endcase
            case (p / 2)
                0: tgt = FIELD_W'(1);
                1: tgt = {FIELD_W{1'b1}};
                2: tgt = FIELD_W'($urandom_range(2, 40));
                default: tgt = FIELD_W'($urandom_range(1, 32'h1FFF_FFFF));
            endcase
            write_target(tgt);
            phase_bytes = bytes_sent;
            while (bytes_sent - phase_bytes < PHASE_BYTES) begin
                build_payload(tgt);
                send_payload();
            end
            i_s_axis_tvalid <= 1'b0;
        end

        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        $display("%0d payloads, %0d bytes, %0d target settings, four idle/stall mixes",
                 payloads_sent, bytes_sent, targets_written + 1);
        $display("outcomes: %0d found, %0d not found, %0d malformed; %0d mismatches",
                 sb.outcome_count[OUT_FOUND], sb.outcome_count[OUT_NOTFOUND],
                 sb.outcome_count[OUT_MALFORMED], sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("protobuf_length_field_extractor_top_test: done, clean");
        else
            $display("protobuf_length_field_extractor_top_test: done, errors");
        $finish;
    end

endmodule
